/* rtl/fcca_pkg.sv */
// Shared types, codes and constants of the FAT16 cluster chain allocator.
package fcca_pkg;

	// Link values with a fixed meaning.
	localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
	localparam logic [15:0] FIRST_DATA   = 16'd2;

	// Allocation never hands out clusters at or above this number.
	localparam int SCAN_LIMIT = 1000;

	// Configuration register map, indexed by paddr[2].
	localparam logic       REG_CLUSTER_SHIFT = 1'b0;
	localparam logic [3:0] CLUSTER_SHIFT_RST = 4'd11;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_WRITE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOSPACE = 2'd1,
		STAT_BROKEN  = 2'd2,
		STAT_BADIDX  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] size_bytes;
		logic [9:0]  cluster_index;
		logic [15:0] link_value;
	} fcca_req_t;

	typedef struct packed {
		logic [9:0]  first_cluster;
		logic [15:0] read_link;
		logic [1:0]  status;
	} fcca_rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DISPATCH,
		S_COUNT,
		S_CHECK,
		S_DECIDE,
		S_LINK,
		S_TERM,
		S_FREE,
		S_READ,
		S_RESP
	} fcca_state_t;

	// Table read port source.
	typedef enum logic [1:0] {
		RD_NONE,
		RD_SCAN,
		RD_REQ,
		RD_NEXT
	} rd_sel_t;

	// Table write port source.
	typedef enum logic [2:0] {
		WR_NONE,
		WR_CLEAR,
		WR_HOST,
		WR_LINK,
		WR_TERM,
		WR_FREE
	} wr_sel_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    req_load;
		logic    scan_init;
		logic    count_en;
		logic    link_en;
		logic    res_status_we;
		status_t res_status;
		logic    res_first_we;
		logic    res_link_we;
		logic    out_load;
	} fcca_cmd_t;

	typedef struct packed {
		req_type_t req_type;
		logic      need_zero;
		logic      idx_zero;
		logic      idx_bad;
		logic      idx_bad_free;
		logic      no_space;
		logic      scan_last;
		logic      scan_end;
		logic      alloc_done;
		logic      walk_end;
		logic      walk_bad;
		logic      clr_last;
	} fcca_stat_t;

endpackage

/* rtl/fcca_dp.sv */
// Datapath of the cluster allocator: link table memory, scan and walk registers, result.
module fcca_dp import fcca_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [3:0] cluster_shift,
	input  fcca_req_t  req,
	input  fcca_cmd_t  cmd,
	output fcca_stat_t st,
	output fcca_rsp_t  rsp
);

	localparam int AW      = $clog2(TABLE_ENTRIES);
	localparam int SCAN_END = (TABLE_ENTRIES < SCAN_LIMIT) ? TABLE_ENTRIES : SCAN_LIMIT;
	localparam int SW      = $clog2(SCAN_END + 1);
	localparam logic [16:0] TE17 = 17'(TABLE_ENTRIES);

	logic [15:0]   link_mem_q [TABLE_ENTRIES];
	logic [15:0]   rdata_s1;
	logic          scan_vld_s1;
	logic [SW-1:0] scan_addr_s1;

	fcca_req_t     req_q;
	logic [32:0]   need_q;
	logic [SW-1:0] scan_q;
	logic [SW-1:0] avail_q;
	logic [SW-1:0] taken_q;
	logic [SW-1:0] first_q;
	logic [SW-1:0] prev_q;
	logic [AW-1:0] cur_q;
	logic [AW-1:0] clr_q;
	logic [9:0]    res_first_q;
	logic [15:0]   res_link_q;
	status_t       res_status_q;
	fcca_rsp_t     out_q;

	logic [32:0]   unit_mask;
	logic [32:0]   need_d;
	logic          mem_we;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          mem_re;
	logic [AW-1:0] rd_addr;
	logic          free_hit;
	logic          link_hit;

	// Clusters needed: size rounded up to whole clusters.
	assign unit_mask = (33'd1 << cluster_shift) - 33'd1;
	assign need_d    = (33'(req.size_bytes) + unit_mask) >> cluster_shift;

	assign free_hit = scan_vld_s1 && (rdata_s1 == 16'd0);
	assign link_hit = cmd.link_en && free_hit && !st.alloc_done;

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = clr_q;
		wr_data = 16'd0;
		unique case (cmd.wr_sel)
			WR_NONE: begin
				mem_we = 1'b0;
			end
			WR_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_q;
			end
			WR_HOST: begin
				mem_we  = 1'b1;
				wr_addr = AW'(req_q.cluster_index);
				wr_data = req_q.link_value;
			end
			WR_LINK: begin
				mem_we  = link_hit && (taken_q != '0);
				wr_addr = AW'(prev_q);
				wr_data = 16'(scan_addr_s1);
			end
			WR_TERM: begin
				mem_we  = 1'b1;
				wr_addr = AW'(prev_q);
				wr_data = END_OF_CHAIN;
			end
			WR_FREE: begin
				mem_we  = 1'b1;
				wr_addr = cur_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		mem_re  = 1'b1;
		rd_addr = AW'(scan_q);
		unique case (cmd.rd_sel)
			RD_NONE: mem_re  = 1'b0;
			RD_SCAN: rd_addr = AW'(scan_q);
			RD_REQ:  rd_addr = AW'(req_q.cluster_index);
			RD_NEXT: rd_addr = AW'(rdata_s1);
			default: mem_re  = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem_q[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rdata_s1 <= link_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			clr_q       <= '0;
		end else begin
			scan_vld_s1 <= (cmd.rd_sel == RD_SCAN);
			if (cmd.wr_sel == WR_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_addr_s1 <= scan_q;
		if (cmd.req_load) begin
			req_q        <= req;
			need_q       <= need_d;
			res_first_q  <= 10'd0;
			res_link_q   <= 16'd0;
			res_status_q <= STAT_OK;
		end
		if (cmd.scan_init) begin
			scan_q  <= SW'(FIRST_DATA);
			avail_q <= '0;
			taken_q <= '0;
		end else if (cmd.rd_sel == RD_SCAN) begin
			scan_q <= scan_q + SW'(1);
		end
		if (cmd.count_en && free_hit) begin
			avail_q <= avail_q + SW'(1);
		end
		if (link_hit) begin
			if (taken_q == '0) begin
				first_q <= scan_addr_s1;
			end
			prev_q  <= scan_addr_s1;
			taken_q <= taken_q + SW'(1);
		end
		if (cmd.rd_sel == RD_REQ) begin
			cur_q <= AW'(req_q.cluster_index);
		end else if (cmd.rd_sel == RD_NEXT) begin
			cur_q <= AW'(rdata_s1);
		end
		if (cmd.res_status_we) begin
			res_status_q <= cmd.res_status;
		end
		if (cmd.res_first_we) begin
			res_first_q <= 10'(first_q);
		end
		if (cmd.res_link_we) begin
			res_link_q <= rdata_s1;
		end
		if (cmd.out_load) begin
			out_q.first_cluster <= res_first_q;
			out_q.read_link     <= res_link_q;
			out_q.status        <= res_status_q;
		end
	end

	always_comb begin
		st.req_type     = req_type_t'(req_q.req_type);
		st.need_zero    = (need_q == 33'd0);
		st.idx_zero     = (req_q.cluster_index == 10'd0);
		st.idx_bad      = (17'(req_q.cluster_index) >= TE17);
		st.idx_bad_free = (req_q.cluster_index == 10'd1) || st.idx_bad;
		st.no_space     = (33'(avail_q) < need_q);
		st.scan_last    = (scan_q == SW'(SCAN_END - 1));
		st.scan_end     = (scan_q == SW'(SCAN_END));
		st.alloc_done   = (33'(taken_q) == need_q);
		st.walk_end     = (rdata_s1 == END_OF_CHAIN);
		st.walk_bad     = (rdata_s1 < FIRST_DATA) || (17'(rdata_s1) >= TE17)
			|| (rdata_s1 == 16'(cur_q));
		st.clr_last     = (clr_q == AW'(TABLE_ENTRIES - 1));
	end

	assign rsp = out_q;

endmodule

/* rtl/fcca_ctrl.sv */
// Controller state machine of the cluster allocator: sequences clear, allocate, free, read, write.
module fcca_ctrl import fcca_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  fcca_stat_t st,
	output fcca_cmd_t  cmd
);

	fcca_state_t state_q;
	fcca_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (st.req_type)
					REQ_ALLOC: state_d = st.need_zero ? S_RESP : S_COUNT;
					REQ_FREE:  state_d = (st.idx_zero || st.idx_bad_free) ? S_RESP : S_FREE;
					REQ_READ:  state_d = st.idx_bad ? S_RESP : S_READ;
					REQ_WRITE: state_d = S_RESP;
					default:   state_d = S_RESP;
				endcase
			end
			S_COUNT: begin
				if (st.scan_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = st.no_space ? S_RESP : S_LINK;
			end
			S_LINK: begin
				if (st.alloc_done) begin
					state_d = S_TERM;
				end
			end
			S_TERM: begin
				state_d = S_RESP;
			end
			S_FREE: begin
				if (st.walk_end || st.walk_bad) begin
					state_d = S_RESP;
				end
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '{
			rd_sel:        RD_NONE,
			wr_sel:        WR_NONE,
			req_load:      1'b0,
			scan_init:     1'b0,
			count_en:      1'b0,
			link_en:       1'b0,
			res_status_we: 1'b0,
			res_status:    STAT_OK,
			res_first_we:  1'b0,
			res_link_we:   1'b0,
			out_load:      1'b0
		};
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_sel = WR_CLEAR;
			end
			S_IDLE: begin
				cmd.req_load = req_valid;
			end
			S_DISPATCH: begin
				unique case (st.req_type)
					REQ_ALLOC: begin
						cmd.scan_init = !st.need_zero;
					end
					REQ_FREE: begin
						if (!st.idx_zero) begin
							if (st.idx_bad_free) begin
								cmd.res_status_we = 1'b1;
								cmd.res_status    = STAT_BADIDX;
							end else begin
								cmd.rd_sel = RD_REQ;
							end
						end
					end
					REQ_READ: begin
						if (st.idx_bad) begin
							cmd.res_status_we = 1'b1;
							cmd.res_status    = STAT_BADIDX;
						end else begin
							cmd.rd_sel = RD_REQ;
						end
					end
					REQ_WRITE: begin
						if (st.idx_bad) begin
							cmd.res_status_we = 1'b1;
							cmd.res_status    = STAT_BADIDX;
						end else begin
							cmd.wr_sel = WR_HOST;
						end
					end
					default: begin
						cmd.res_status_we = 1'b0;
					end
				endcase
			end
			S_COUNT: begin
				cmd.rd_sel   = RD_SCAN;
				cmd.count_en = 1'b1;
			end
			S_CHECK: begin
				cmd.count_en = 1'b1;
			end
			S_DECIDE: begin
				if (st.no_space) begin
					cmd.res_status_we = 1'b1;
					cmd.res_status    = STAT_NOSPACE;
				end else begin
					cmd.scan_init = 1'b1;
				end
			end
			S_LINK: begin
				cmd.link_en = 1'b1;
				cmd.wr_sel  = WR_LINK;
				if (!st.alloc_done && !st.scan_end) begin
					cmd.rd_sel = RD_SCAN;
				end
			end
			S_TERM: begin
				cmd.wr_sel       = WR_TERM;
				cmd.res_first_we = 1'b1;
			end
			S_FREE: begin
				cmd.wr_sel = WR_FREE;
				if (!st.walk_end) begin
					if (st.walk_bad) begin
						cmd.res_status_we = 1'b1;
						cmd.res_status    = STAT_BROKEN;
					end else begin
						cmd.rd_sel = RD_NEXT;
					end
				end
			end
			S_READ: begin
				cmd.res_link_we = 1'b1;
			end
			S_RESP: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd.out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

/* rtl/fat16_cluster_chain_allocator_unit.sv */
// Top level of the FAT16 cluster chain allocator: configuration port, controller and datapath.
// This block keeps a FAT16 link table of TABLE_ENTRIES 16-bit entries in a single on-chip
// memory with one write port and one registered read port, and serves one request at a time.
// After reset the block runs a clearing pass that writes zero to every entry, one entry per
// cycle, and req_ready stays low until that pass ends; configuration writes are taken during
// that pass. An allocate request rounds size_bytes up to whole clusters of 2^cluster_shift
// bytes, then makes two passes over clusters 2 up to the lesser of 1000 and TABLE_ENTRIES at
// one entry per memory read cycle: the first counts free entries, so a request that does not
// fit returns no-space and leaves the table untouched, and the second links the lowest free
// entries and ends the chain with 0xFFFF. The counting pass always covers the whole scan range
// (998 clusters by default), while the linking pass stops after the last cluster it takes. A
// zero size answers with cluster 0. A free request follows the chain through the read port at
// one link per cycle, clearing each entry as it goes; it reports a broken chain on a zero,
// out-of-range or self-pointing link, and a free of cluster 0 or of a bad start answers
// without a walk. The result sits in an output register, so a new request can be accepted
// in the cycle after the result is loaded, while that result still waits for rsp_ready.
// The only register is cluster_shift at byte address 0 (reset 11).
module fat16_cluster_chain_allocator_unit import fcca_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  fcca_req_t   req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output fcca_rsp_t   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0] cluster_shift_q;
	fcca_cmd_t  cmd;
	fcca_stat_t st;

	// The single register decodes on the word index; the other word reads as zero.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CLUSTER_SHIFT) ? 32'(cluster_shift_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_shift_q <= CLUSTER_SHIFT_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_CLUSTER_SHIFT)) begin
			cluster_shift_q <= pwdata[3:0];
		end
	end

	// The controller sequences every request; the datapath owns the table and all payload.
	fcca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	fcca_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cluster_shift (cluster_shift_q),
		.req           (req),
		.cmd           (cmd),
		.st            (st),
		.rsp           (rsp)
	);

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the FAT16 cluster chain allocator unit.
`timescale 1ns / 1ps

module tb_top;
	import fcca_pkg::*;

	// The table size used for the instance.
	localparam int LINK_ENTRIES = 1024;

	// The slowest legal request is an allocate, which makes two passes over the scan range.
	// The run sends about 585 requests, with random stalls and gaps on both sides.
	// The watchdog limit leaves ample room for them all, plus the clearing pass.
	localparam int unsigned CYCLE_LIMIT = 8000000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	fcca_req_t   req;
	logic        rsp_valid;
	logic        rsp_ready;
	fcca_rsp_t   rsp;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// The testbench's own copy of the link table and of the cluster shift register.
	logic [15:0] fat_model [LINK_ENTRIES];
	logic [3:0]  shift_model;

	// Responses still owed by the block, oldest first, and the heads of the chains that
	// allocations handed out and that nobody has freed yet.
	fcca_rsp_t   fat_rsp_q [$];
	int          chain_heads [$];

	// Random idling on both sides is allowed only while this is set.
	bit          idle_on;

	int          mismatch_count;
	int          req_seen [4];
	int          status_seen [4];
	bit          shift_seen [16];
	int unsigned cycle_count = 0;
	fcca_rsp_t   want;

	fat16_cluster_chain_allocator_unit #(
		.TABLE_ENTRIES(LINK_ENTRIES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// A 10 ns clock. It starts low, so the first falling edge comes at 10 ns.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// This function applies one request to the table copy and returns the response the
	// block must give. Allocation scans clusters 2 up to the lesser of 1000 and the table
	// size. It counts the free entries first, so an allocation that does not fit leaves
	// the table alone. A free walk clears each entry it visits. It stops cleanly at
	// end of chain, and it reports a broken chain on a zero link, a link of one or a link
	// past the table.
	function automatic fcca_rsp_t fat_apply(fcca_req_t r);
		fcca_rsp_t   ans;
		logic [63:0] need;
		int          scan_top;
		int          avail;
		int          taken;
		int          prev;
		int          c;
		int          cur;
		int          nxt;
		int          steps;
		ans = '0;
		ans.status = STAT_OK;
		scan_top = (LINK_ENTRIES < SCAN_LIMIT) ? LINK_ENTRIES : SCAN_LIMIT;
		case (req_type_t'(r.req_type))
			REQ_ALLOC: begin
				// Round the byte count up to whole clusters. A zero size takes nothing.
				need = (64'(r.size_bytes) + (64'd1 << shift_model) - 64'd1) >> shift_model;
				if (need != 0) begin
					avail = 0;
					for (c = FIRST_DATA; c < scan_top; c++) begin
						if (fat_model[c] == 16'd0)
							avail++;
					end
					if (64'(avail) < need) begin
						ans.status = STAT_NOSPACE;
					end else begin
						taken = 0;
						prev = 0;
						for (c = FIRST_DATA; c < scan_top && 64'(taken) < need; c++) begin
							if (fat_model[c] == 16'd0) begin
								if (taken == 0)
									ans.first_cluster = 10'(c);
								else
									fat_model[prev] = 16'(c);
								fat_model[c] = END_OF_CHAIN;
								prev = c;
								taken++;
							end
						end
					end
				end
			end
			REQ_FREE: begin
				cur = r.cluster_index;
				// Freeing cluster zero is a no-op. Cluster one is never a chain start.
				if (cur != 0) begin
					if (cur < FIRST_DATA || cur >= LINK_ENTRIES) begin
						ans.status = STAT_BADIDX;
					end else begin
						ans.status = STAT_BROKEN;
						for (steps = 0; steps <= LINK_ENTRIES; steps++) begin
							nxt = fat_model[cur];
							fat_model[cur] = 16'd0;
							if (nxt == END_OF_CHAIN) begin
								ans.status = STAT_OK;
								break;
							end
							if (nxt < FIRST_DATA || nxt >= LINK_ENTRIES)
								break;
							cur = nxt;
						end
					end
				end
			end
			REQ_READ: begin
				if (r.cluster_index < LINK_ENTRIES)
					ans.read_link = fat_model[r.cluster_index];
				else
					ans.status = STAT_BADIDX;
			end
			default: begin
				if (r.cluster_index < LINK_ENTRIES)
					fat_model[r.cluster_index] = r.link_value;
				else
					ans.status = STAT_BADIDX;
			end
		endcase
		return ans;
	endfunction

	// This task sends one request. It holds valid and the payload from one falling edge
	// until the rising edge that accepts the request, and the prediction is made at that
	// accepting edge. Now and then, while idling is allowed, valid drops for a random gap
	// first.
	task automatic send_req(input req_type_t kind, input logic [31:0] bytes,
			input logic [9:0] idx, input logic [15:0] val);
		fcca_req_t r;
		fcca_rsp_t ans;
		r.req_type = kind;
		r.size_bytes = bytes;
		r.cluster_index = idx;
		r.link_value = val;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req = r;
		req_valid = 1'b1;
		do
			@(posedge clk);
		while (req_ready !== 1'b1);
		ans = fat_apply(r);
		fat_rsp_q.push_back(ans);
		req_seen[kind]++;
		if (kind == REQ_ALLOC && ans.first_cluster != 0)
			chain_heads.push_back(ans.first_cluster);
	endtask

	// This task withdraws the last, already accepted request and waits until every
	// response the block owes has come back.
	task automatic drain_responses();
		@(negedge clk);
		req_valid = 1'b0;
		while (fat_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// This task writes the cluster shift register with an APB setup cycle and an access cycle.
	// It is only called with the block idle. The upper data bits carry noise, which the
	// register must ignore.
	task automatic write_cluster_shift(input logic [3:0] value);
		drain_responses();
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {REG_CLUSTER_SHIFT, 2'b00};
		pwdata = {28'($urandom()), value};
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		shift_model = value;
		shift_seen[value] = 1'b1;
	endtask

	// After reset every entry reads as free. Entry 0 takes any value and is never allocated.
	// Freeing cluster 0 does nothing, and a free of cluster 1 is a bad index.
	task automatic test_reset_and_index();
		send_req(REQ_READ, 32'd0, 10'd1023, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd0, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd1, 16'd0);
		send_req(REQ_WRITE, 32'd0, 10'd0, END_OF_CHAIN);
		send_req(REQ_READ, 32'd0, 10'd0, 16'd0);
	endtask

	// Size rounding at the reset shift of 11 (2 KiB clusters) covers a zero size, one byte,
	// one byte past a cluster, and the largest size, which cannot fit.
	task automatic test_alloc_sizes();
		send_req(REQ_ALLOC, 32'd0, 10'd0, 16'd0);
		send_req(REQ_ALLOC, 32'd1, 10'd0, 16'd0);
		send_req(REQ_ALLOC, 32'd2049, 10'd0, 16'd0);
		send_req(REQ_ALLOC, 32'hFFFF_FFFF, 10'd0, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd2, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd3, 16'd0);
	endtask

	// This test takes every cluster below the scan limit in one chain and checks that one
	// more cluster is refused. It then frees the long chain.
	task automatic test_table_full();
		send_req(REQ_ALLOC, 32'(998 * 2048), 10'd0, 16'd0);
		send_req(REQ_ALLOC, 32'd1, 10'd0, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd2, 16'd0);
	endtask

	// Hand-built chains through the write port. The first ends cleanly past the scan limit.
	// The others break: one link points past the table, one points at cluster 1, and one
	// loops until it meets an entry that the walk has already cleared.
	task automatic test_broken_chains();
		send_req(REQ_WRITE, 32'd0, 10'd5, 16'd1023);
		send_req(REQ_WRITE, 32'd0, 10'd1023, END_OF_CHAIN);
		send_req(REQ_FREE, 32'd0, 10'd5, 16'd0);
		send_req(REQ_WRITE, 32'd0, 10'd6, 16'h0400);
		send_req(REQ_FREE, 32'd0, 10'd6, 16'd0);
		send_req(REQ_WRITE, 32'd0, 10'd7, 16'd1);
		send_req(REQ_FREE, 32'd0, 10'd7, 16'd0);
		send_req(REQ_WRITE, 32'd0, 10'd10, 16'd11);
		send_req(REQ_WRITE, 32'd0, 10'd11, 16'd10);
		send_req(REQ_FREE, 32'd0, 10'd10, 16'd0);
	endtask

	// The shift extremes: with shift 0 each byte is a cluster, and with shift 15 each
	// cluster is 32 KiB.
	task automatic test_shift_extremes();
		write_cluster_shift(4'd0);
		send_req(REQ_ALLOC, 32'd3, 10'd0, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd2, 16'd0);
		write_cluster_shift(4'd15);
		send_req(REQ_ALLOC, 32'd32769, 10'd0, 16'd0);
		send_req(REQ_FREE, 32'd0, 10'd2, 16'd0);
	endtask

	// This task makes one random request. Most of them follow the block's normal use:
	// allocations of a few clusters, frees of chains that were handed out, and reads near
	// the bottom of the table, where the chains live. The rest is noise: random writes
	// that damage chains, frees at random places, and sizes that are huge or zero.
	task automatic random_request();
		int          pick;
		int          k;
		int          slot;
		int          need;
		logic [63:0] bytes;
		logic [9:0]  idx;
		logic [15:0] val;
		pick = $urandom_range(0, 99);
		if (pick < 32) begin
			k = $urandom_range(0, 19);
			if (k == 0) begin
				bytes = 64'd0;
			end else if (k == 1) begin
				bytes = 64'($urandom());
			end else begin
				need = (k == 2) ? $urandom_range(100, 998) : $urandom_range(1, 24);
				bytes = (64'(need - 1) << shift_model)
					+ 64'($urandom_range(1, 1 << shift_model));
			end
			send_req(REQ_ALLOC, bytes[31:0], 10'($urandom()), 16'($urandom()));
		end else if (pick < 58 && chain_heads.size() != 0) begin
			slot = $urandom_range(0, chain_heads.size() - 1);
			idx = 10'(chain_heads[slot]);
			chain_heads.delete(slot);
			send_req(REQ_FREE, $urandom(), idx, 16'($urandom()));
		end else if (pick < 78) begin
			idx = ($urandom_range(0, 2) == 0) ? 10'($urandom()) : 10'($urandom_range(0, 127));
			send_req(REQ_READ, $urandom(), idx, 16'($urandom()));
		end else if (pick < 90) begin
			case ($urandom_range(0, 3))
				0: begin
					idx = 10'($urandom());
					val = 16'($urandom());
				end
				1: begin
					idx = 10'($urandom_range(1000, 1023));
					val = 16'($urandom());
				end
				2: begin
					idx = 10'($urandom());
					val = END_OF_CHAIN;
				end
				default: begin
					idx = 10'($urandom_range(0, 127));
					val = 16'd0;
				end
			endcase
			send_req(REQ_WRITE, $urandom(), idx, val);
		end else begin
			idx = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1)) : 10'($urandom());
			send_req(REQ_FREE, $urandom(), idx, 16'($urandom()));
		end
	endtask

	// This task runs one phase of random requests at a given cluster shift. Halfway through,
	// the sender holds back until the block has answered everything.
	task automatic run_random_phase(input logic [3:0] shift, input int count, input bit idle);
		write_cluster_shift(shift);
		idle_on = idle;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				drain_responses();
			random_request();
		end
	endtask

	// Response side stalls come in random bursts while idling is allowed.
	always @(negedge clk) begin
		if (idle_on && $urandom_range(0, 7) == 0) begin
			rsp_ready = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
			rsp_ready = 1'b1;
		end
	end

	// This block compares every accepted response, field by field, with the oldest
	// prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready) begin
			if (!$isunknown(rsp.status))
				status_seen[rsp.status]++;
			if (fat_rsp_q.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: response with no request pending: first %0d link %h status %0d",
						$time, rsp.first_cluster, rsp.read_link, rsp.status);
				mismatch_count++;
			end else begin
				want = fat_rsp_q.pop_front();
				if (rsp.first_cluster !== want.first_cluster || rsp.read_link !== want.read_link
						|| rsp.status !== want.status) begin
					if (mismatch_count < 10)
						$display("%0t: expected first %0d link %h status %0d, got first %0d link %h status %0d",
							$time, want.first_cluster, want.read_link, want.status,
							rsp.first_cluster, rsp.read_link, rsp.status);
					mismatch_count++;
				end
			end
		end
	end

	// The watchdog ends a run that hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d responses outstanding", cycle_count,
			fat_rsp_q.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b0;
		mismatch_count = 0;
		shift_model = CLUSTER_SHIFT_RST;
		shift_seen[CLUSTER_SHIFT_RST] = 1'b1;
		foreach (fat_model[i])
			fat_model[i] = 16'd0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// The directed tests run first, most of them at the reset shift, so that they also show that
		// the register resets to 11. The block's clearing pass holds off the first request.
		test_reset_and_index();
		test_alloc_sizes();
		test_table_full();
		test_broken_chains();
		test_shift_extremes();

		// The random phases run at the low end of the normal range, at both extremes and at
		// a random value. The last phase returns to the reset value and runs with no idling.
		run_random_phase(4'd9, 110, 1'b1);
		run_random_phase(4'd0, 110, 1'b1);
		run_random_phase(4'd15, 110, 1'b1);
		run_random_phase(4'($urandom_range(0, 15)), 110, 1'b1);
		run_random_phase(4'd11, 115, 1'b0);

		@(negedge clk);
		req_valid = 1'b0;
		drain_responses();
		repeat (16) @(posedge clk);

		$display("Covered %0d allocate, %0d free, %0d read and %0d write requests at %0d shift values",
			req_seen[REQ_ALLOC], req_seen[REQ_FREE], req_seen[REQ_READ], req_seen[REQ_WRITE],
			shift_seen.sum() with (int'(item)));
		$display("Responses: %0d ok, %0d no space, %0d broken chain, %0d bad index; %0d mismatches",
			status_seen[STAT_OK], status_seen[STAT_NOSPACE], status_seen[STAT_BROKEN],
			status_seen[STAT_BADIDX], mismatch_count);
		if (mismatch_count == 0 && fat_rsp_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
rtl/fcca_pkg.sv
rtl/fcca_dp.sv
rtl/fcca_ctrl.sv
rtl/fat16_cluster_chain_allocator_unit.sv
tb/tb_top.sv
